[rtl/rlm_pkg.sv]
// Shared constants and types for the smoothed RMS level meter.
package rlm_pkg;

  localparam int MAX_BLOCK_DEF = 8192;   // default samples per block
  localparam int SAMPLE_W      = 16;
  localparam int SQ_W          = 31;     // a 16-bit square reaches 2^30
  localparam int LEVEL_W       = 7;
  localparam int KEEP_W        = 9;
  localparam int KEEP_RESET    = 179;
  localparam int KEEP_FULL     = 256;
  localparam int AVG_W         = 15;     // smoothed level, Q8
  localparam int AVG_MAX       = 25600;  // 100.0 in Q8
  localparam int LEVEL_MAX     = 100;
  localparam int LVL_MUL       = 200;
  localparam int LVL_SHIFT     = 23;
  localparam int LVL_ROUND     = 4194304;  // half of 2^23
  localparam int ROUND_Q8      = 128;
  localparam int FRAC_SHIFT    = 16;     // sum scaled by 2^16 before the divide
  localparam int Q_DEPTH       = 4;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_MULT,
    BK_SAT,
    BK_MIX,
    BK_FIN
  } bk_state_t;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic empty;
    logic room;    // at least two free entries
  } rlm_qstat_t;

endpackage

[rtl/rlm_front.sv]
// Front end: squares samples and accumulates per-block sum and count.
module rlm_front
  import rlm_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF,
  parameter int CNT_W     = $clog2(MAX_BLOCK + 1),
  parameter int SUM_W     = SQ_W - 1 + CNT_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                      in_last,
  input  logic                      in_fresh,
  output logic                      in_ready,
  input  rlm_qstat_t                qstat,
  output logic                      push,
  output logic [SUM_W+CNT_W:0]      push_data
);

  logic                       accept;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic                       s1_v_r;
  logic [SQ_W-1:0]            s1_sq_r;
  logic                       s1_last_r;
  logic                       s1_fresh_r;
  logic [SUM_W-1:0]           sum_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       pend_clr_r;
  logic                       add_en;
  logic [SUM_W-1:0]           sum_nxt;
  logic [CNT_W-1:0]           cnt_nxt;
  logic                       clr_nxt;

  // room for this beat and one still in the square stage
  assign in_ready = qstat.room;
  assign accept   = in_valid & in_ready;
  assign sq_full  = (2*SAMPLE_W)'(in_sample) * (2*SAMPLE_W)'(in_sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sq_r    <= sq_full[SQ_W-1:0];
      s1_last_r  <= in_last;
      s1_fresh_r <= in_fresh;
    end
  end

  // samples past the block limit are dropped
  assign add_en  = cnt_r < CNT_W'(MAX_BLOCK);
  assign sum_nxt = add_en ? sum_r + SUM_W'(s1_sq_r) : sum_r;
  assign cnt_nxt = add_en ? cnt_r + CNT_W'(1) : cnt_r;
  assign clr_nxt = pend_clr_r | s1_fresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      cnt_r      <= '0;
      pend_clr_r <= 1'b0;
    end else if (s1_v_r) begin
      if (s1_last_r) begin
        sum_r      <= '0;
        cnt_r      <= '0;
        pend_clr_r <= 1'b0;
      end else begin
        sum_r      <= sum_nxt;
        cnt_r      <= cnt_nxt;
        pend_clr_r <= clr_nxt;
      end
    end
  end

  assign push      = s1_v_r & s1_last_r;
  assign push_data = {clr_nxt, cnt_nxt, sum_nxt};

endmodule

[rtl/rlm_fifo.sv]
// Small register queue carrying closed blocks from front to back end.
module rlm_fifo
  import rlm_pkg::*;
#(
  parameter int W     = 59,
  parameter int DEPTH = Q_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output rlm_qstat_t   qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             full;

  assign full        = cnt_r == CNT_W'(DEPTH);
  assign qstat.empty = cnt_r == '0;
  assign qstat.room  = cnt_r <= CNT_W'(DEPTH - 2);
  assign pop_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !qstat.empty)
    else $error("queue pop while empty");
`endif

endmodule

[rtl/rlm_back.sv]
// Back end: divide, square root, level scaling and exponential smoothing.
module rlm_back
  import rlm_pkg::*;
#(
  parameter int CNT_W = 14,
  parameter int SUM_W = 44
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [KEEP_W-1:0]        keep_weight,
  input  rlm_qstat_t               qstat,
  output logic                     pop,
  input  logic [SUM_W+CNT_W:0]     q_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [LEVEL_W-1:0]       out_level
);

  localparam int DIV_W  = SUM_W + FRAC_SHIFT;
  localparam int QW     = (DIV_W + 1) / 2;
  localparam int RAD_W  = 2 * QW;
  localparam int STEP_W = $clog2(DIV_W);
  localparam int PROD_W = QW + 8;
  localparam int P1_W   = AVG_W + KEEP_W;
  localparam int P2_W   = LEVEL_W + KEEP_W;

  bk_state_t          state_r, state_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [CNT_W-1:0]   dvs_r;
  logic [DIV_W-1:0]   div_r;
  logic [CNT_W-1:0]   drem_r;
  logic [RAD_W-1:0]   rad_r;
  logic [QW:0]        srem_r;
  logic [QW-1:0]      root_r;
  logic [PROD_W-1:0]  prod_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [P1_W-1:0]    p1_r;
  logic [P2_W-1:0]    p2_r;
  logic               zero_r;
  logic [AVG_W-1:0]   avg_r;
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;

  logic               div_last, sqrt_last, fin_go;
  logic [CNT_W:0]     dtrial;
  logic               dge;
  logic [DIV_W-1:0]   div_nxt;
  logic [CNT_W-1:0]   drem_nxt;
  logic [QW+2:0]      strial, sbase;
  logic               sge;
  logic [QW+2:0]      sdiff;
  logic [PROD_W:0]    rnd;
  logic [PROD_W-LVL_SHIFT:0] lsh;
  logic [KEEP_W-1:0]  keep_eff;
  logic [P1_W:0]      mix;
  logic [AVG_W-1:0]   avg_new;
  logic [AVG_W:0]     out_rnd;
  logic [AVG_W-8:0]   out_q;

  assign div_last  = step_r == STEP_W'(DIV_W - 1);
  assign sqrt_last = step_r == STEP_W'(QW - 1);
  assign fin_go    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!qstat.empty) begin
          pop       = 1'b1;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV:  if (div_last) state_nxt = BK_SQRT;
      BK_SQRT: if (sqrt_last) state_nxt = BK_MULT;
      BK_MULT: state_nxt = BK_SAT;
      BK_SAT:  state_nxt = BK_MIX;
      BK_MIX:  state_nxt = BK_FIN;
      BK_FIN:  if (fin_go) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // restoring divide, one quotient bit per cycle
  assign dtrial   = {drem_r, div_r[DIV_W-1]};
  assign dge      = dtrial >= {1'b0, dvs_r};
  assign drem_nxt = dge ? CNT_W'(dtrial - {1'b0, dvs_r}) : CNT_W'(dtrial);
  assign div_nxt  = {div_r[DIV_W-2:0], dge};

  // digit-by-digit root, one result bit per cycle
  assign sbase  = {srem_r, rad_r[RAD_W-1 -: 2]};
  assign strial = {1'b0, root_r, 2'b01};
  assign sge    = sbase >= strial;
  assign sdiff  = sbase - strial;

  assign rnd = {1'b0, prod_r} + (PROD_W+1)'(LVL_ROUND);
  assign lsh = rnd[PROD_W:LVL_SHIFT];

  assign keep_eff = (keep_weight > KEEP_W'(KEEP_FULL)) ? KEEP_W'(KEEP_FULL) : keep_weight;

  assign mix     = (P1_W+1)'(p1_r) + (P1_W+1)'({p2_r, 8'b0}) + (P1_W+1)'(ROUND_Q8);
  assign avg_new = zero_r ? {lvl_r, 8'b0} : mix[AVG_W+7:8];
  assign out_rnd = (AVG_W+1)'(avg_new) + (AVG_W+1)'(ROUND_Q8);
  assign out_q   = out_rnd[AVG_W:8];

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        step_r <= '0;
        dvs_r  <= q_data[SUM_W+CNT_W-1:SUM_W];
        div_r  <= {q_data[SUM_W-1:0], FRAC_SHIFT'(0)};
        drem_r <= '0;
      end
      BK_DIV: begin
        div_r  <= div_nxt;
        drem_r <= drem_nxt;
        if (div_last) begin
          step_r <= '0;
          rad_r  <= (dvs_r == '0) ? '0 : RAD_W'(div_nxt);
          srem_r <= '0;
          root_r <= '0;
        end else begin
          step_r <= step_r + STEP_W'(1);
        end
      end
      BK_SQRT: begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        srem_r <= sge ? sdiff[QW:0] : sbase[QW:0];
        root_r <= {root_r[QW-2:0], sge};
        step_r <= step_r + STEP_W'(1);
      end
      BK_MULT: prod_r <= PROD_W'(root_r) * PROD_W'(LVL_MUL);
      BK_SAT: begin
        lvl_r <= (lsh > (PROD_W-LVL_SHIFT+1)'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                            : lsh[LEVEL_W-1:0];
      end
      BK_MIX: begin
        p1_r   <= P1_W'(avg_r) * P1_W'(keep_eff);
        p2_r   <= P2_W'(lvl_r) * P2_W'(KEEP_W'(KEEP_FULL) - keep_eff);
        zero_r <= avg_r == '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && q_data[SUM_W+CNT_W]) begin
        avg_r <= '0;
      end
      if (state_r == BK_FIN && fin_go) begin
        avg_r       <= avg_new;
        out_valid_r <= 1'b1;
        out_level_r <= (out_q > (AVG_W-7)'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                       : out_q[LEVEL_W-1:0];
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_level_r <= LEVEL_W'(LEVEL_MAX))
    else $error("level above full scale");
  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    avg_r <= AVG_W'(AVG_MAX))
    else $error("smoothed average above full scale");
`endif

endmodule

[rtl/rms_level_meter_smoothed.sv]
// Top level of the smoothed RMS level meter.
//
// Input stream: one 16-bit signed PCM sample per beat on in_tdata; in_tlast
// closes a measurement block, in_tuser clears the smoothed average before
// the sample. Output stream: one smoothed level (0..100 percent) per block.
// Configuration: cfg_we writes cfg_wdata into the keep weight (Q8, reset 179,
// values above 256 act as 256). Write it only while the meter is idle.
//
// Throughput: one sample per cycle while the queue has room. The front end
// registers the square, then accumulates it, and queues each closed block in
// a 4-entry queue. The back end takes a block through a bit-serial restoring
// divide, a bit-serial square root, then the scaling and smoothing states
// MULT, SAT, MIX and FIN.
// Blocks shorter than the back-end processing time fill the queue, and
// in_tready then drops until a block drains.
// Reset (rst_n low, synchronous) empties the queue, clears sum, count and
// average, and restores the keep weight. A stalled receiver holds the result
// in the output register; the back end finishes the next block and waits,
// and the input keeps flowing until the queue fills.
module rms_level_meter_smoothed
  import rlm_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,    // [15:0] sample
  input  logic              in_tlast,    // last_in_block
  input  logic              in_tuser,    // [0] new_recording
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,   // [6:0] level, [7] zero
  input  logic              cfg_we,
  input  logic [KEEP_W-1:0] cfg_wdata    // keep_weight
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = SQ_W - 1 + CNT_W;   // MAX_BLOCK squares of up to 2^30
  localparam int ENT_W = SUM_W + CNT_W + 1;  // {clear, count, sum}

  logic [KEEP_W-1:0]  keep_r;
  rlm_qstat_t         qstat;
  logic               push, pop;
  logic [ENT_W-1:0]   push_data, pop_data;
  logic [LEVEL_W-1:0] level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= KEEP_W'(KEEP_RESET);
    end else if (cfg_we) begin
      keep_r <= cfg_wdata;
    end
  end

  rlm_front #(
    .MAX_BLOCK (MAX_BLOCK),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_sample ($signed(in_tdata)),
    .in_last   (in_tlast),
    .in_fresh  (in_tuser),
    .in_ready  (in_tready),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  rlm_fifo #(
    .W     (ENT_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  rlm_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .keep_weight (keep_r),
    .qstat       (qstat),
    .pop         (pop),
    .q_data      (pop_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_level   (level)
  );

  assign out_tdata = {1'b0, level};

endmodule

[sim/rms_level_meter_smoothed_tb.sv]
// Self-checking testbench for the smoothed RMS level meter: directed and random sample streams.
`timescale 1ns / 100ps

module rms_level_meter_smoothed_tb;
  import rlm_pkg::*;

  localparam int BLOCK_CAP  = MAX_BLOCK_DEF;
  localparam int SETTLE_CYC = 200;    // longer than the back end takes per block at this size
  localparam int HOLD_CYC   = 1200;   // long receiver hold-off, fills the block queue
  localparam int QUIET_MAX  = 20000;  // watchdog: cycles with no beat on either side
  localparam int N_PHASES   = 8;
  localparam int PHASE_ITEMS = 200;   // at least 1600 random samples over all phases

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;   // [15:0] sample
  logic              in_tlast = 1'b0; // last_in_block
  logic              in_tuser = 1'b0; // [0] new_recording
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;       // [6:0] level, [7] zero
  logic              cfg_we = 1'b0;
  logic [KEEP_W-1:0] cfg_wdata = '0;  // keep_weight

  rms_level_meter_smoothed #(.MAX_BLOCK(BLOCK_CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Level predictor: its own copy of the accumulator, the average and the weight
  // ---------------------------------------------------------------------------
  logic [43:0]       sq_sum    = '0;   // block sum of squares
  int                blk_count = 0;    // samples counted in the open block
  logic [AVG_W-1:0]  avg_q8    = '0;   // smoothed level, Q8
  logic [KEEP_W-1:0] keep_reg  = KEEP_RESET;

  logic [6:0] want_levels [$];         // expected levels, oldest first
  int         pin_level = -1;          // typed-in expectation for the current beat
  int         errors = 0;

  // bit-serial integer square root, two bits of the radicand per step
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] trial;
    r   = '0;
    rem = '0;
    for (int i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | ((v >> (2 * i)) & 64'd3);
      trial = (r << 2) | 64'd1;
      r     = r << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        r   = r | 64'd1;
      end
    end
    return r;
  endfunction

  task automatic predict_level(input logic [15:0] smp, input logic last, input logic fresh,
                               output bit emits, output logic [6:0] lvl);
    int          sv;
    logic [63:0] q;
    logic [63:0] lv;
    logic [63:0] k;
    logic [63:0] a;
    emits = 1'b0;
    lvl   = '0;
    if (fresh)
      avg_q8 = '0;
    // samples past the block cap are dropped, but a closing flag still counts
    if (blk_count < BLOCK_CAP) begin
      sv        = int'($signed(smp));
      sq_sum    = sq_sum + 44'(64'(sv * sv));
      blk_count = blk_count + 1;
    end
    if (last) begin
      if (blk_count != 0)
        q = root64(({20'b0, sq_sum} << FRAC_SHIFT) / 64'(blk_count));
      else
        q = '0;
      lv = (q * LVL_MUL + 64'(LVL_ROUND)) >> LVL_SHIFT;
      if (lv > LEVEL_MAX)
        lv = LEVEL_MAX;
      k = (keep_reg > KEEP_FULL) ? 64'(KEEP_FULL) : 64'(keep_reg);
      if (avg_q8 == 0)
        a = lv << 8;
      else
        a = (64'(avg_q8) * k + (lv << 8) * (KEEP_FULL - k) + ROUND_Q8) >> 8;
      avg_q8 = a[AVG_W-1:0];
      a = (a + ROUND_Q8) >> 8;
      if (a > LEVEL_MAX)
        a = LEVEL_MAX;
      lvl       = a[6:0];
      emits     = 1'b1;
      sq_sum    = '0;
      blk_count = 0;
    end
  endtask

  // input monitor: every accepted sample beat goes through the predictor
  always @(posedge clk) begin
    bit         emits;
    logic [6:0] lvl;
    if (rst_n && in_tvalid && in_tready) begin
      predict_level(in_tdata, in_tlast, in_tuser, emits, lvl);
      if (emits)
        want_levels.push_back(pin_level >= 0 ? 7'(pin_level) : lvl);
    end
  end

  // output monitor: compare each level beat with the oldest expectation
  always @(posedge clk) begin
    logic [6:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (want_levels.size() == 0) begin
        if (errors < 10)
          $display("mismatch: level beat %0d with nothing expected", out_tdata);
        errors++;
      end else begin
        want = want_levels.pop_front();
        if (out_tdata !== {1'b0, want}) begin
          if (errors < 10)
            $display("mismatch: level expected %0d, got %0d (tdata %h)",
                     want, out_tdata[6:0], out_tdata);
          errors++;
        end
      end
    end
  end

  // watchdog: any stretch without a single beat on either side ends the run
  int quiet = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  bit hold_req  = 1'b0;

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        // counted here, not in the sender, so the sender keeps offering beats
        for (int n = 0; n < HOLD_CYC; n++) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int idle_pct = 0;
  int phase_sent;

  // one sample beat; entered and left on a falling edge
  task automatic push_sample(input logic [15:0] smp, input logic last, input logic fresh,
                             input int pin);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    pin_level  = pin;
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tlast  <= last;
    in_tuser  <= fresh;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    @(negedge clk);
  endtask

  // random block: mostly short, amplitude picked per block so levels spread 0..100
  task automatic send_block();
    int          len;
    int          amp;
    int          pick;
    logic [15:0] smp;
    pick = $urandom_range(99);
    if (pick < 70)
      len = $urandom_range(1, 8);
    else if (pick < 95)
      len = $urandom_range(9, 64);
    else
      len = $urandom_range(65, 300);
    if ($urandom_range(1))
      amp = 1 << $urandom_range(15);
    else
      amp = $urandom_range(1, 32768);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 5)
        smp = 16'h8000;
      else if (pick < 10)
        smp = 16'h7FFF;
      else if (pick < 13)
        smp = 16'($urandom);
      else
        smp = 16'($urandom_range(0, 2 * amp - 1) - amp);
      push_sample(smp, i == len - 1, $urandom_range(99) < 3, -1);
    end
    phase_sent += len;
  endtask

  // drop valid and wait until every expected level has come, then let the
  // back end settle before touching the weight
  task automatic drain();
    in_tvalid <= 1'b0;
    while (want_levels.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    keep_reg   = v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // directed rows; pin >= 0 is the level read straight off the scaling rules
  typedef struct packed {
    logic [15:0] smp;
    logic        last;
    logic        fresh;
    int          pin;
  } probe_t;

  localparam int N_PROBES = 15;
  probe_t probes [N_PROBES] = '{
    '{16'h0000, 1'b1, 1'b0,   0},  // silent block right after reset
    '{16'h8000, 1'b1, 1'b1, 100},  // most negative sample, level saturates
    '{16'h7FFF, 1'b1, 1'b0, 100},  // most positive sample
    '{16'h0000, 1'b1, 1'b0,  -1},  // average decays toward zero
    '{16'h0000, 1'b0, 1'b1,  -1},  // new recording mid-block, sum kept
    '{16'h0000, 1'b1, 1'b0,   0},  // cleared average takes level 0
    '{16'h0001, 1'b0, 1'b0,  -1},
    '{16'hFFFF, 1'b0, 1'b0,  -1},
    '{16'h5555, 1'b0, 1'b0,  -1},
    '{16'hAAAA, 1'b1, 1'b0,  -1},
    '{16'h4000, 1'b1, 1'b1, 100},
    '{16'h2000, 1'b1, 1'b0,  -1},  // half scale mixed into a full average
    '{16'h2000, 1'b1, 1'b1,  50},  // new recording on the closing beat
    '{16'h8000, 1'b0, 1'b0,  -1},
    '{16'h7FFF, 1'b1, 1'b1, 100}
  };

  // per phase: keep weight, sender idle %, receiver stall %
  int keep_plan  [N_PHASES] = '{0, 256, 511, 1, 128, 255, 257, 179};
  int idle_plan  [N_PHASES] = '{0, 82, 0, 31, 0, 82, 0, 31};
  int stall_plan [N_PHASES] = '{0, 0, 82, 31, 0, 0, 82, 31};

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset weight
    for (int i = 0; i < N_PROBES; i++)
      push_sample(probes[i].smp, probes[i].last, probes[i].fresh, probes[i].pin);
    drain();

    // random phases
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 4)
        write_keep(KEEP_W'($urandom_range(0, KEEP_FULL)));
      else if (p == 6 && $urandom_range(1))
        write_keep(KEEP_W'($urandom_range(KEEP_FULL + 1, (1 << KEEP_W) - 1)));
      else
        write_keep(KEEP_W'(keep_plan[p]));
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      // receiver goes quiet for a long stretch while short blocks keep coming
      if (p == 4)
        hold_req = 1'b1;
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS)
        send_block();
      drain();
    end

    stall_pct = 0;
    if (want_levels.size() != 0) begin
      $display("mismatch: %0d expected levels never arrived", want_levels.size());
      errors++;
    end
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
rtl/rlm_pkg.sv
rtl/rlm_front.sv
rtl/rlm_fifo.sv
rtl/rlm_back.sv
rtl/rms_level_meter_smoothed.sv
sim/rms_level_meter_smoothed_tb.sv
